FILE: rtl/cefss_pkg.sv
package cefss_pkg;

   typedef struct packed {
      logic [31:0] timestamp_us;
      logic        trigger_valid;
      logic        sync_valid;
      logic [3:0]  trigger_index;
      logic [15:0] fuel_pulse_us;
      logic [16:0] injection_angle;
      logic [16:0] ignition_angle;
      logic [15:0] dwell_us;
      logic        rpm_ign_cut;
      logic        boost_ign_cut;
   } req_word_type;

   typedef struct packed {
      logic [31:0] revolution_us;
      logic [2:0]  injector_channel;
      logic [23:0] injector_delay_us;
      logic [2:0]  ignitor_channel;
      logic [23:0] ignitor_wait_us;
      logic        dwell_slot;
      logic [15:0] dwell_out_us;
      logic        fuel_calc_request;
      logic [1:0]  fuel_calc_cylinder;
      logic        ign_calc_request;
      logic        map_sample_request;
      logic        sync_error;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic start_inj;
      logic start_ign;
      logic finish;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic need_div;
   } status_type;

   localparam logic [1:0] CSR_INJ_ORDER = 2'd0;
   localparam logic [1:0] CSR_IGN_ORDER = 2'd1;
   localparam logic [1:0] CSR_DEGREES   = 2'd2;

   localparam int DIV_STEPS = 49;
   localparam logic [23:0] WAIT_MAX = 24'hFFFFFF;

endpackage

FILE: rtl/cefss_datapath.sv
module cefss_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  cefss_pkg::req_word_type req_word,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [9:0]            csr_data,
   input  cefss_pkg::cmd_type    cmd,
   output cefss_pkg::status_type status,
   output cefss_pkg::rsp_word_type result
);
   logic [7:0]  inj_order_ff, ign_order_ff;
   logic [9:0]  degrees_ff;
   logic [31:0] hist_ff [4];
   logic [31:0] rev_ff;
   cefss_pkg::req_word_type item_ff;
   cefss_pkg::rsp_word_type work_ff;
   cefss_pkg::rsp_word_type rsp_ff;
   logic [48:0] quot_ff;
   logic [16:0] rem_ff;
   logic [48:0] prod_ff;
   logic [5:0]  step_ff;
   logic        busy_ff;
   logic [16:0] divisor;
   logic [17:0] trial;
   logic [3:0]  idx;
   logic [1:0]  slot;
   logic        odd_pos, even_pos, active;
   logic [2:0]  coil;
   logic [48:0] quot_in;
   logic [16:0] rem_in;

   assign divisor = (degrees_ff == 10'd0) ? 17'd100 : 17'(degrees_ff) * 17'd100;
   assign trial   = {rem_ff, prod_ff[48 - step_ff]};
   assign rem_in  = (trial >= {1'b0, divisor}) ? 17'(trial - {1'b0, divisor}) : trial[16:0];
   assign quot_in = {quot_ff[47:0], (trial >= {1'b0, divisor})};

   assign idx      = (item_ff.trigger_index == 4'd9) ? 4'd1 : item_ff.trigger_index;
   assign odd_pos  = (idx == 4'd1) || (idx == 4'd3) || (idx == 4'd5) || (idx == 4'd7);
   assign even_pos = (idx == 4'd2) || (idx == 4'd4) || (idx == 4'd6) || (idx == 4'd8);
   assign active   = item_ff.trigger_valid && item_ff.sync_valid;
   assign slot     = 2'(idx[3:1] - 3'd1);
   assign coil     = {1'b0, ign_order_ff[{slot, 1'b0} +: 2]} + 3'd1;

   assign status.need_div = active && even_pos;
   assign status.div_done = busy_ff && (step_ff == 6'(cefss_pkg::DIV_STEPS - 1));

   assign result = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         inj_order_ff <= 8'd57;
         ign_order_ff <= 8'd228;
         degrees_ff   <= 10'd360;
         rev_ff       <= '0;
         busy_ff      <= 1'b0;
         for (int i = 0; i < 4; i++) hist_ff[i] <= '0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               cefss_pkg::CSR_INJ_ORDER: inj_order_ff <= csr_data[7:0];
               cefss_pkg::CSR_IGN_ORDER: ign_order_ff <= csr_data[7:0];
               cefss_pkg::CSR_DEGREES:   degrees_ff   <= csr_data;
               default: ;
            endcase
         end
         if (cmd.load) begin
            item_ff    <= req_word;
            hist_ff[0] <= hist_ff[1];
            hist_ff[1] <= hist_ff[2];
            hist_ff[2] <= hist_ff[3];
            hist_ff[3] <= req_word.timestamp_us;
            if (req_word.trigger_valid) rev_ff <= req_word.timestamp_us - hist_ff[0];
         end
         if (cmd.start_inj || cmd.start_ign) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            quot_ff <= '0;
            prod_ff <= rev_ff * (cmd.start_inj ? item_ff.injection_angle
                                               : item_ff.ignition_angle);
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            quot_ff <= quot_in;
            step_ff <= step_ff + 6'd1;
            if (status.div_done) busy_ff <= 1'b0;
         end
         if (cmd.load) begin
            work_ff <= '0;
         end else if (cmd.finish) begin
            work_ff.revolution_us <= rev_ff;
            if (active) begin
               work_ff.sync_error <= (item_ff.trigger_index == 4'd9);
               if (odd_pos) begin
                  work_ff.fuel_calc_request  <= 1'b1;
                  work_ff.fuel_calc_cylinder <= idx[2:1];
                  work_ff.ign_calc_request   <= 1'b1;
               end
               if (even_pos) begin
                  work_ff.map_sample_request <= 1'b1;
                  work_ff.ign_calc_request   <= (idx >= 4'd6);
               end
            end
         end
         if (status.div_done && !cmd.finish) begin
            work_ff.injector_channel <= {1'b0, inj_order_ff[{slot, 1'b0} +: 2]} + 3'd1;
            if (quot_in > 49'(item_ff.fuel_pulse_us)) begin
               work_ff.injector_delay_us <= (quot_in - 49'(item_ff.fuel_pulse_us)
                                            > 49'(cefss_pkg::WAIT_MAX)) ? cefss_pkg::WAIT_MAX
                                           : 24'(quot_in - 49'(item_ff.fuel_pulse_us));
            end else begin
               work_ff.injector_delay_us <= 24'd1;
            end
         end
         if (status.div_done && cmd.finish && !(item_ff.rpm_ign_cut || item_ff.boost_ign_cut)) begin
            work_ff.ignitor_channel <= coil;
            work_ff.dwell_slot      <= ~coil[0];
            work_ff.dwell_out_us    <= item_ff.dwell_us;
            if (quot_in > 49'(item_ff.dwell_us)) begin
               work_ff.ignitor_wait_us <= (quot_in - 49'(item_ff.dwell_us)
                                           > 49'(cefss_pkg::WAIT_MAX)) ? cefss_pkg::WAIT_MAX
                                          : 24'(quot_in - 49'(item_ff.dwell_us));
            end else begin
               work_ff.ignitor_wait_us <= '0;
            end
         end
         if (cmd.emit) rsp_ff <= work_ff;
      end
   end
endmodule

FILE: rtl/cefss_control.sv
module cefss_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  cefss_pkg::status_type status,
   output cefss_pkg::cmd_type    cmd
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DEC  = 3'd1;
   localparam logic [2:0] ST_INJ  = 3'd2;
   localparam logic [2:0] ST_IGNS = 3'd3;
   localparam logic [2:0] ST_IGN  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: if (req_valid) begin
            cmd.load = 1'b1;
            state_in = ST_DEC;
         end
         ST_DEC: if (status.need_div) begin
            cmd.start_inj = 1'b1;
            state_in = ST_INJ;
         end else begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_INJ: if (status.div_done) state_in = ST_IGNS;
         ST_IGNS: begin
            cmd.start_ign = 1'b1;
            state_in = ST_IGN;
         end
         ST_IGN: if (status.div_done) begin
            cmd.finish = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: if (!rsp_valid_ff || !rsp_stall) begin
            cmd.emit = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: rtl/crank_event_fuel_spark_scheduler_unit.sv
// Crank event fuel and spark scheduler.
// req_ channel: one crank trigger word per handshake (req_valid high, req_stall low).
// rsp_ channel: one result word per request, held while rsp_stall is high.
// csr_ channel: index 0 injector order, 1 coil order, 2 degrees per revolution;
// csr_ready is always high, and writes belong between items.
// rsp_valid rises once a word has passed the decode and output states for odd,
// idle or unsynced words; even positions also take two passes of a 49-step
// restoring divider (injection angle, then ignition angle) sharing one
// quotient-bit-per-cycle unit, with a restart state between the passes.
// One word is in work at a time; a new word is taken only after the previous
// result has been moved into the output register.
// Reset clears the timestamp history and revolution time and loads the order
// and degree defaults; no result is pending after reset.
// While rsp_stall is high the result word holds in the output register; the next
// word is still taken and worked, then waits with req_stall high until the
// output register is free.
module crank_event_fuel_spark_scheduler_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  cefss_pkg::req_word_type req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output cefss_pkg::rsp_word_type rsp_word,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [1:0]              csr_index,
   input  logic [9:0]              csr_data
);
   cefss_pkg::cmd_type    cmd;
   cefss_pkg::status_type status;

   assign csr_ready = 1'b1;

   cefss_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd));

   cefss_datapath u_datapath (
      .clock(clock), .reset(reset), .req_word(req_word), .csr_valid(csr_valid),
      .csr_index(csr_index), .csr_data(csr_data), .cmd(cmd), .status(status),
      .result(rsp_word));
endmodule

FILE: rtl/cefss_checker.sv
module cefss_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input cefss_pkg::rsp_word_type rsp_word
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word)) else $error("rsp held");
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("second word taken");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid)) else $error("accept flow");
   a_chan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.injector_channel <= 3'd4 && rsp_word.ignitor_channel <= 3'd4)
      else $error("channel range");
endmodule

bind crank_event_fuel_spark_scheduler_unit cefss_checker u_cefss_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word));
